// ===== sv/assert_macros.svh =====
// Assertion macros shared by the collector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/ucc_pkg.sv =====
// Shared types and constants of the distinct codepoint collector.
package ucc_pkg;

    // Input operation codes.
    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_TEXT     = 3'd1;
    localparam logic [2:0] OP_STR_END  = 3'd2;
    localparam logic [2:0] OP_SCAN_END = 3'd3;
    localparam logic [2:0] OP_READ     = 3'd4;

    // Result kinds.
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_ENTRY   = 1'b1;

    // UTF-8 length boundaries.
    localparam logic [20:0] CP_2BYTE_MIN = 21'h00080;
    localparam logic [20:0] CP_3BYTE_MIN = 21'h00800;
    localparam logic [20:0] CP_4BYTE_MIN = 21'h10000;

    // Command slots per item in the front end and depth of the command queue.
    localparam int FRONT_SLOTS = 4;
    localparam int CMDQ_DEPTH  = 4;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_RECORD,
        CMD_SUMMARY,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [20:0] cp;
        logic [1:0]  style;
        logic [31:0] font;
    } cmd_t;

    typedef enum logic [1:0] {
        EX_IDLE,
        EX_SEARCH,
        EX_DRAIN
    } ex_state_t;

endpackage

// ===== sv/utf8_distinct_codepoint_collector.sv =====
// Top level of the UTF-8 distinct codepoint collector.
//
// The slave stream carries one item per handshake: an operation in s_tuser and
// a text byte, style tag and font tag in s_tdata. The master stream returns an
// end-of-scan summary (m_tuser = 0) or a drained set entry (m_tuser = 1) with
// its UTF-8 encoding; m_tlast marks the final entry. The user must write
// requested_styles via cfg_wr_en/cfg_wr_data only while idle (not enforced).
//
// The front end turns an item into zero to four commands and emits one per
// cycle while the queue accepts them; it takes no new item until every
// command of the last one has gone out. A four-entry queue decouples it from
// the execution unit, whose set memory has a single read port: a recorded
// codepoint needs no search when the set is empty or full, else it is
// compared serially with the stored entries. An end of scan passes through
// the slot list, the command queue and the output register to m_tvalid.
//
// Reset empties the set, clears the decoder and style flags and sets
// requested_styles to all ones; no memory clearing pass is needed. While the
// receiver stalls the result holds in the output register, the queue fills
// and s_tready falls.
module utf8_distinct_codepoint_collector import ucc_pkg::*; #(
    parameter int SET_CAPACITY = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data,   // requested_styles
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,       // text_byte[7:0], style_tag[9:8], font_tag[41:10]
    input  logic [2:0]   s_tuser,       // operation[2:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,       // style_mask[3:0], scan_font[35:4], entry_total[42:36],
                                        // codepoint[63:43], utf8_bytes[95:64],
                                        // utf8_length[98:96]
    output logic [0:0]   m_tuser,       // kind[0]
    output logic         m_tlast        // last
);

    cmd_t        front_cmd, queue_cmd;
    logic        front_valid, front_ready;
    logic        queue_valid, queue_ready;
    logic        res_kind, res_last;
    logic [3:0]  res_mask;
    logic [31:0] res_font, res_bytes;
    logic [6:0]  res_total;
    logic [20:0] res_cp;
    logic [2:0]  res_len;

    // Decoder and command issue.
    ucc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .in_op    (s_tuser),
        .in_byte  (s_tdata[7:0]),
        .in_style (s_tdata[9:8]),
        .in_font  (s_tdata[41:10]),
        .q_valid  (front_valid),
        .q_ready  (front_ready),
        .q_cmd    (front_cmd)
    );

    // Command queue between the two halves.
    ucc_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    // Set maintenance and result generation.
    ucc_exec #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (queue_valid),
        .q_ready       (queue_ready),
        .q_cmd         (queue_cmd),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_kind        (res_kind),
        .m_style_mask  (res_mask),
        .m_scan_font   (res_font),
        .m_entry_total (res_total),
        .m_codepoint   (res_cp),
        .m_utf8_bytes  (res_bytes),
        .m_utf8_length (res_len),
        .m_last        (res_last)
    );

    // Pack the result fields, lowest field first, zero filled to whole bytes.
    assign m_tdata = {5'd0, res_len, res_bytes, res_cp, res_total, res_font, res_mask};
    assign m_tuser = res_kind;
    assign m_tlast = res_last;

endmodule

// ===== sv/ucc_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module ucc_ram #(
    parameter int WIDTH  = 21,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/ucc_front.sv =====
// Front end: accepts items, runs the UTF-8 decoder and issues commands.
`include "assert_macros.svh"

module ucc_front import ucc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  in_op,
    input  logic [7:0]  in_byte,
    input  logic [1:0]  in_style,
    input  logic [31:0] in_font,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);

    localparam int SLOT_CW = $clog2(FRONT_SLOTS + 1);
    localparam int SLOT_IW = $clog2(FRONT_SLOTS);

    logic [23:0]        pend_bytes_reg, pend_bytes_next;
    logic [1:0]         pend_need_reg, pend_need_next;
    logic [1:0]         pend_have_reg, pend_have_next;
    logic [31:0]        font_reg, font_next;
    logic               font_latched_reg, font_latched_next;
    cmd_t               slots_reg [FRONT_SLOTS];
    cmd_t               slots_next [FRONT_SLOTS];
    logic [SLOT_CW-1:0] slot_cnt_reg, slot_cnt_next;

    cmd_t               list_n [FRONT_SLOTS];
    logic [SLOT_CW-1:0] list_cnt;

    logic        accept, pop;
    logic        is_text, is_end, latch_font, cont, pend, complete;
    logic        do_flush, do_fresh, do_cont;
    logic [1:0]  lead_need;
    logic [20:0] comp_cp;
    logic [31:0] font_eff;

    function automatic cmd_t make_cmd(cmd_kind_t k, logic [20:0] cp, logic [1:0] st,
                                      logic [31:0] f);
        cmd_t c;
        c.kind  = k;
        c.cp    = cp;
        c.style = st;
        c.font  = f;
        return c;
    endfunction

    assign s_ready = (slot_cnt_reg == '0);
    assign accept  = s_valid && s_ready;
    assign q_valid = (slot_cnt_reg != '0);
    assign q_cmd   = slots_reg[0];
    assign pop     = q_valid && q_ready;

    // Item classification against the pending sequence.
    always_comb begin
        is_text    = (in_op == OP_TEXT) && (in_byte != 8'd0);
        is_end     = ((in_op == OP_TEXT) && (in_byte == 8'd0)) || (in_op == OP_STR_END) ||
                     (in_op == OP_SCAN_END);
        latch_font = ((in_op == OP_TEXT) || (in_op == OP_STR_END)) && !font_latched_reg;
        font_eff   = latch_font ? in_font : font_reg;
        cont       = (in_byte[7:6] == 2'b10);
        pend       = (pend_need_reg != 2'd0);
        do_flush   = pend && (is_end || (is_text && !cont));
        do_fresh   = is_text && (!pend || !cont);
        do_cont    = is_text && pend && cont;
        complete   = do_cont && ((({1'b0, pend_have_reg} + 3'd1) >= {1'b0, pend_need_reg}) ||
                                 (pend_have_reg >= 2'd2));

        if (in_byte[7:5] == 3'b110) begin
            lead_need = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
            lead_need = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
            lead_need = 2'd3;
        end else begin
            lead_need = 2'd0;
        end

        case (pend_need_reg)
            2'd1:    comp_cp = {10'd0, pend_bytes_reg[4:0], in_byte[5:0]};
            2'd2:    comp_cp = {5'd0, pend_bytes_reg[3:0], pend_bytes_reg[13:8], in_byte[5:0]};
            default: comp_cp = {pend_bytes_reg[2:0], pend_bytes_reg[13:8],
                                pend_bytes_reg[21:16], in_byte[5:0]};
        endcase
    end

    // Command list of the current item, in the order the commands must run.
    always_comb begin
        for (int i = 0; i < FRONT_SLOTS; i++) begin
            list_n[i] = '0;
        end
        list_cnt = '0;
        if (in_op == OP_START) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_CLEAR, 21'd0, in_style, 32'd0);
            list_cnt = list_cnt + 1'b1;
        end
        if (do_flush) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_RECORD, {13'd0, pend_bytes_reg[7:0]},
                                                     in_style, font_eff);
            list_cnt = list_cnt + 1'b1;
            if (pend_have_reg >= 2'd1) begin
                list_n[list_cnt[SLOT_IW-1:0]] =
                    make_cmd(CMD_RECORD, {13'd0, pend_bytes_reg[15:8]}, in_style, font_eff);
                list_cnt = list_cnt + 1'b1;
            end
            if (pend_have_reg >= 2'd2) begin
                list_n[list_cnt[SLOT_IW-1:0]] =
                    make_cmd(CMD_RECORD, {13'd0, pend_bytes_reg[23:16]}, in_style, font_eff);
                list_cnt = list_cnt + 1'b1;
            end
        end
        if (do_fresh && (lead_need == 2'd0)) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_RECORD, {13'd0, in_byte},
                                                     in_style, font_eff);
            list_cnt = list_cnt + 1'b1;
        end
        if (complete) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_RECORD, comp_cp, in_style, font_eff);
            list_cnt = list_cnt + 1'b1;
        end
        if (in_op == OP_SCAN_END) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_SUMMARY, 21'd0, in_style, font_eff);
            list_cnt = list_cnt + 1'b1;
        end
        if (in_op == OP_READ) begin
            list_n[list_cnt[SLOT_IW-1:0]] = make_cmd(CMD_DRAIN, 21'd0, in_style, font_eff);
            list_cnt = list_cnt + 1'b1;
        end
    end

    // Decoder state and slot list updates.
    always_comb begin
        pend_bytes_next   = pend_bytes_reg;
        pend_need_next    = pend_need_reg;
        pend_have_next    = pend_have_reg;
        font_next         = font_reg;
        font_latched_next = font_latched_reg;
        slots_next        = slots_reg;
        slot_cnt_next     = slot_cnt_reg;

        if (accept) begin
            slots_next    = list_n;
            slot_cnt_next = list_cnt;
            if (in_op == OP_START) begin
                pend_bytes_next   = '0;
                pend_need_next    = '0;
                pend_have_next    = '0;
                font_next         = '0;
                font_latched_next = 1'b0;
            end else begin
                if (latch_font) begin
                    font_next         = in_font;
                    font_latched_next = 1'b1;
                end
                if (is_end || do_flush || complete) begin
                    pend_bytes_next = '0;
                    pend_need_next  = '0;
                    pend_have_next  = '0;
                end
                if (do_fresh && (lead_need != 2'd0)) begin
                    pend_bytes_next = {16'd0, in_byte};
                    pend_need_next  = lead_need;
                    pend_have_next  = 2'd0;
                end
                if (do_cont && !complete) begin
                    pend_have_next = pend_have_reg + 2'd1;
                    if (pend_have_reg == 2'd0) begin
                        pend_bytes_next[15:8] = in_byte;
                    end else begin
                        pend_bytes_next[23:16] = in_byte;
                    end
                end
            end
        end else if (pop) begin
            for (int i = 0; i < FRONT_SLOTS - 1; i++) begin
                slots_next[i] = slots_reg[i + 1];
            end
            slots_next[FRONT_SLOTS - 1] = '0;
            slot_cnt_next = slot_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bytes_reg   <= '0;
            pend_need_reg    <= '0;
            pend_have_reg    <= '0;
            font_reg         <= '0;
            font_latched_reg <= 1'b0;
            slot_cnt_reg     <= '0;
        end else begin
            pend_bytes_reg   <= pend_bytes_next;
            pend_need_reg    <= pend_need_next;
            pend_have_reg    <= pend_have_next;
            font_reg         <= font_next;
            font_latched_reg <= font_latched_next;
            slot_cnt_reg     <= slot_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slots_reg <= slots_next;
    end

    `ASSERT_IMPLIES(a_pend_idle, aclk, aresetn, pend_need_reg == 2'd0, pend_have_reg == 2'd0, "continuations counted with no sequence pending")
    `ASSERT_IMPLIES(a_pend_order, aclk, aresetn, pend_need_reg != 2'd0, pend_have_reg < pend_need_reg, "pending sequence holds too many continuations")
    `ASSERT_HOLDS(a_slot_bound, aclk, aresetn, slot_cnt_reg <= SLOT_CW'(FRONT_SLOTS), "command slot count overflow")

endmodule

// ===== sv/ucc_cmd_fifo.sv =====
// Short command queue between the front end and the execution unit.
module ucc_cmd_fifo import ucc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);

    cmd_t             mem_reg [CMDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    logic             push, pull;

    assign in_ready  = (cnt_reg != (PTR_W + 1)'(CMDQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pull      = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pull ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pull) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pull && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== sv/ucc_exec.sv =====
// Execution unit: distinct set search and append, summary and drain results.
`include "assert_macros.svh"

module ucc_exec import ucc_pkg::*; #(
    parameter int SET_CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [3:0]  m_style_mask,
    output logic [31:0] m_scan_font,
    output logic [6:0]  m_entry_total,
    output logic [20:0] m_codepoint,
    output logic [31:0] m_utf8_bytes,
    output logic [2:0]  m_utf8_length,
    output logic        m_last
);

    localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
    localparam int ADDR_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);

    ex_state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] drain_reg, drain_next;
    logic [CNT_W-1:0] srch_addr_reg, srch_addr_next;
    logic [3:0]       seen_reg, seen_next;
    logic [3:0]       req_reg, req_next;
    logic [20:0]      cp_reg, cp_next;
    logic [31:0]      font_hold_reg, font_hold_next;
    logic             cmp_valid_reg, cmp_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_last_reg;
    logic [3:0]  out_mask_reg;
    logic [31:0] out_font_reg, out_bytes_reg;
    logic [6:0]  out_total_reg;
    logic [20:0] out_cp_reg;
    logic [2:0]  out_len_reg;

    logic              out_free, pop, drain_empty, drain_last;
    logic              search_hit, search_miss, issue, drain_emit, summary_load;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [20:0]       ram_wr_data, ram_rd_data;
    logic [31:0]       enc_bytes;
    logic [2:0]        enc_len;
    logic [3:0]        mask_seen, mask_req, summary_mask;

    ucc_ram #(
        .WIDTH (21),
        .DEPTH (SET_CAPACITY)
    ) u_set_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EX_IDLE: begin
                if (pop && (q_cmd.kind == CMD_RECORD) && (count_reg != '0) &&
                    (count_reg < CAP_CNT)) begin
                    state_next = EX_SEARCH;
                end else if (pop && (q_cmd.kind == CMD_DRAIN) && !drain_empty) begin
                    state_next = EX_DRAIN;
                end
            end
            EX_SEARCH: begin
                if (search_hit || search_miss) begin
                    state_next = EX_IDLE;
                end
            end
            EX_DRAIN: begin
                if (out_free) begin
                    state_next = EX_IDLE;
                end
            end
            default: state_next = EX_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        out_free     = !out_valid_reg || m_ready;
        q_ready      = (state_reg == EX_IDLE) && ((q_cmd.kind != CMD_SUMMARY) || out_free);
        pop          = q_valid && q_ready;
        drain_empty  = (count_reg == '0) || (drain_reg >= count_reg);
        drain_last   = ((drain_reg + 1'b1) >= count_reg);
        issue        = (state_reg == EX_SEARCH) && (srch_addr_reg < count_reg);
        search_hit   = (state_reg == EX_SEARCH) && cmp_valid_reg && (ram_rd_data == cp_reg);
        search_miss  = (state_reg == EX_SEARCH) && cmp_valid_reg && !search_hit &&
                       cmp_last_reg;
        drain_emit   = (state_reg == EX_DRAIN) && out_free;
        summary_load = pop && (q_cmd.kind == CMD_SUMMARY);
        ram_wr_en    = (pop && (q_cmd.kind == CMD_RECORD) && (count_reg == '0)) || search_miss;
        ram_wr_data  = (state_reg == EX_IDLE) ? q_cmd.cp : cp_reg;
        ram_rd_addr  = (state_reg == EX_SEARCH) ? srch_addr_reg[ADDR_W-1:0]
                                                : drain_reg[ADDR_W-1:0];
    end

    // Summary mask: regular style stands in when nothing else survives.
    always_comb begin
        mask_seen    = (seen_reg == 4'd0) ? 4'd1 : seen_reg;
        mask_req     = mask_seen & req_reg;
        summary_mask = (mask_req == 4'd0) ? 4'd1 : mask_req;
    end

    // UTF-8 encoding of the entry being drained.
    always_comb begin
        if (ram_rd_data < CP_2BYTE_MIN) begin
            enc_bytes = {11'd0, ram_rd_data};
            enc_len   = 3'd1;
        end else if (ram_rd_data < CP_3BYTE_MIN) begin
            enc_bytes = {16'd0, 2'b10, ram_rd_data[5:0], 3'b110, ram_rd_data[10:6]};
            enc_len   = 3'd2;
        end else if (ram_rd_data < CP_4BYTE_MIN) begin
            enc_bytes = {8'd0, 2'b10, ram_rd_data[5:0], 2'b10, ram_rd_data[11:6],
                         4'b1110, ram_rd_data[15:12]};
            enc_len   = 3'd3;
        end else begin
            enc_bytes = {2'b10, ram_rd_data[5:0], 2'b10, ram_rd_data[11:6],
                         2'b10, ram_rd_data[17:12], 5'b11110, ram_rd_data[20:18]};
            enc_len   = 3'd4;
        end
    end

    // Set state updates.
    always_comb begin
        count_next     = count_reg;
        drain_next     = drain_reg;
        seen_next      = seen_reg;
        req_next       = cfg_wr_en ? cfg_wr_data : req_reg;
        cp_next        = cp_reg;
        font_hold_next = font_hold_reg;
        srch_addr_next = issue ? srch_addr_reg + 1'b1 : srch_addr_reg;

        if (pop) begin
            case (q_cmd.kind)
                CMD_CLEAR: begin
                    count_next = '0;
                    drain_next = '0;
                    seen_next  = 4'd0;
                end
                CMD_RECORD: begin
                    seen_next      = seen_reg | (4'd1 << q_cmd.style);
                    cp_next        = q_cmd.cp;
                    srch_addr_next = '0;
                    if (count_reg == '0) begin
                        count_next = CNT_W'(1);
                    end
                end
                CMD_SUMMARY: begin
                    drain_next = '0;
                end
                CMD_DRAIN: begin
                    font_hold_next = q_cmd.font;
                    if (drain_empty) begin
                        drain_next = '0;
                    end
                end
                default: ;
            endcase
        end
        if (search_miss) begin
            count_next = count_reg + 1'b1;
        end
        if (drain_emit) begin
            if (drain_last) begin
                count_next = '0;
                drain_next = '0;
            end else begin
                drain_next = drain_reg + 1'b1;
            end
        end
        out_valid_next = (summary_load || drain_emit) ? 1'b1 :
                         (m_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= EX_IDLE;
            count_reg     <= '0;
            drain_reg     <= '0;
            srch_addr_reg <= '0;
            seen_reg      <= 4'd0;
            req_reg       <= 4'hF;
            cmp_valid_reg <= 1'b0;
            cmp_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            srch_addr_reg <= srch_addr_next;
            seen_reg      <= seen_next;
            req_reg       <= req_next;
            cmp_valid_reg <= issue;
            cmp_last_reg  <= issue && ((srch_addr_reg + 1'b1) == count_reg);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cp_reg        <= cp_next;
        font_hold_reg <= font_hold_next;
        if (summary_load) begin
            out_kind_reg  <= KIND_SUMMARY;
            out_mask_reg  <= summary_mask;
            out_font_reg  <= q_cmd.font;
            out_total_reg <= 7'(count_reg);
            out_cp_reg    <= 21'd0;
            out_bytes_reg <= 32'd0;
            out_len_reg   <= 3'd1;
            out_last_reg  <= 1'b0;
        end else if (drain_emit) begin
            out_kind_reg  <= KIND_ENTRY;
            out_mask_reg  <= 4'd0;
            out_font_reg  <= font_hold_reg;
            out_total_reg <= 7'(count_reg);
            out_cp_reg    <= ram_rd_data;
            out_bytes_reg <= enc_bytes;
            out_len_reg   <= enc_len;
            out_last_reg  <= drain_last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_style_mask  = out_mask_reg;
    assign m_scan_font   = out_font_reg;
    assign m_entry_total = out_total_reg;
    assign m_codepoint   = out_cp_reg;
    assign m_utf8_bytes  = out_bytes_reg;
    assign m_utf8_length = out_len_reg;
    assign m_last        = out_last_reg;

    `ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= CAP_CNT, "set count beyond capacity")
    `ASSERT_HOLDS(a_drain_bound, aclk, aresetn, (drain_reg == '0) || (drain_reg < count_reg), "drain position past the stored entries")
    `ASSERT_IMPLIES(a_last_entry, aclk, aresetn, out_valid_reg && out_last_reg, out_kind_reg == KIND_ENTRY, "last flag on a summary result")

endmodule
